// ----- rtl/fchm_pkg.sv -----
package fchm_pkg;

	localparam int LEVEL_BITS = 10;
	localparam int COLOUR_BITS = 8;
	localparam int DIV_STEPS = LEVEL_BITS;
	localparam int COUNT_BITS = $clog2(DIV_STEPS);
	localparam int OUT_FIELD_BITS = 3 * COLOUR_BITS + LEVEL_BITS;
	localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
	localparam int USER_BITS = 2;
	localparam logic REQ_MEASURE = 1'b0;
	localparam logic REQ_MAP = 1'b1;
	localparam logic [LEVEL_BITS-1:0] LEVEL_TOP = {LEVEL_BITS{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAS_MAX,
		ST_MEAS_MIN,
		ST_MAP_RANGE,
		ST_MAP_LOW,
		ST_MAP_HIGH,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} sub_flags_t;

endpackage

// ----- rtl/fchm_sub.sv -----
module fchm_sub #(
	parameter int WIDTH = 34
) (
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output logic [WIDTH-1:0] diff,
	output fchm_pkg::sub_flags_t flags
);

	assign diff = a - b;
	assign flags.neg = diff[WIDTH-1];
	assign flags.zero = (diff == '0);

endmodule

// ----- rtl/false_colour_heatmap_mapper.sv -----
// Maps signed fixed-point temperature samples to false colours. A frame is sent twice: measure
// items (tuser bit 0 low) update a running minimum and maximum, cleared first when tuser bit 1
// is high, and produce no output item; map items (tuser bit 0 high) produce one output item
// with the ramp level floor(1024*(v-min)/(max-min)), saturated to 0..1023, and its
// blue-cyan-green-yellow-red colour. All comparisons and the division run through one shared
// subtractor; a new item is taken only in idle. A measure item passes through ST_MEAS_MAX and
// ST_MEAS_MIN. A map item goes from ST_MAP_RANGE, ST_MAP_LOW or ST_MAP_HIGH to ST_OUT when the
// range is empty, the sample is at most the minimum or at least the maximum; else it runs
// the ten-step restoring division in ST_DIV. ST_OUT holds the output item until it is taken.
module false_colour_heatmap_mapper #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// sample
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	// req_type, start_frame
	input  logic [fchm_pkg::USER_BITS-1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// red, green, blue, level
	output logic [fchm_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

	localparam int ALU_BITS = SAMPLE_BITS + 2;
	localparam logic [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [fchm_pkg::COUNT_BITS-1:0] LAST_STEP =
		fchm_pkg::COUNT_BITS'(fchm_pkg::DIV_STEPS - 1);

	fchm_pkg::state_t state_q, state_next;

	logic [SAMPLE_BITS-1:0] v_q;
	logic [SAMPLE_BITS-1:0] min_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [SAMPLE_BITS-1:0] rem_q;
	logic [fchm_pkg::LEVEL_BITS-1:0] k_q;
	logic [fchm_pkg::COUNT_BITS-1:0] count_q;

	logic [ALU_BITS-1:0] op_a, op_b, diff;
	fchm_pkg::sub_flags_t flags;

	logic [ALU_BITS-1:0] v_ext, min_ext, max_ext;
	logic in_fire;
	logic [fchm_pkg::COLOUR_BITS-1:0] red, green, blue, low;

	assign v_ext = {{2{v_q[SAMPLE_BITS-1]}}, v_q};
	assign min_ext = {{2{min_q[SAMPLE_BITS-1]}}, min_q};
	assign max_ext = {{2{max_q[SAMPLE_BITS-1]}}, max_q};
	assign in_fire = s_axis_tvalid && s_axis_tready;

	fchm_sub #(
		.WIDTH(ALU_BITS)
	) u_sub (
		.a(op_a),
		.b(op_b),
		.diff(diff),
		.flags(flags)
	);

	always_comb begin
		state_next = state_q;
		case (state_q)
			fchm_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (s_axis_tuser[0] == fchm_pkg::REQ_MAP) begin
						state_next = fchm_pkg::ST_MAP_RANGE;
					end else begin
						state_next = fchm_pkg::ST_MEAS_MAX;
					end
				end
			end
			fchm_pkg::ST_MEAS_MAX: state_next = fchm_pkg::ST_MEAS_MIN;
			fchm_pkg::ST_MEAS_MIN: state_next = fchm_pkg::ST_IDLE;
			fchm_pkg::ST_MAP_RANGE: begin
				if (flags.neg || flags.zero) begin
					state_next = fchm_pkg::ST_OUT;
				end else begin
					state_next = fchm_pkg::ST_MAP_LOW;
				end
			end
			fchm_pkg::ST_MAP_LOW: begin
				if (flags.neg || flags.zero) begin
					state_next = fchm_pkg::ST_OUT;
				end else begin
					state_next = fchm_pkg::ST_MAP_HIGH;
				end
			end
			fchm_pkg::ST_MAP_HIGH: begin
				if (flags.neg) begin
					state_next = fchm_pkg::ST_DIV;
				end else begin
					state_next = fchm_pkg::ST_OUT;
				end
			end
			fchm_pkg::ST_DIV: begin
				if (count_q == LAST_STEP) begin
					state_next = fchm_pkg::ST_OUT;
				end
			end
			fchm_pkg::ST_OUT: begin
				if (m_axis_tready) begin
					state_next = fchm_pkg::ST_IDLE;
				end
			end
			default: state_next = fchm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		op_a = v_ext;
		op_b = min_ext;
		case (state_q)
			fchm_pkg::ST_IDLE: s_axis_tready = 1'b1;
			fchm_pkg::ST_MEAS_MAX: begin
				op_a = max_ext;
				op_b = v_ext;
			end
			fchm_pkg::ST_MEAS_MIN: begin
				op_a = v_ext;
				op_b = min_ext;
			end
			fchm_pkg::ST_MAP_RANGE: begin
				op_a = max_ext;
				op_b = min_ext;
			end
			fchm_pkg::ST_MAP_LOW: begin
				op_a = v_ext;
				op_b = min_ext;
			end
			fchm_pkg::ST_MAP_HIGH: begin
				op_a = v_ext;
				op_b = max_ext;
			end
			fchm_pkg::ST_DIV: begin
				op_a = {1'b0, rem_q, 1'b0};
				op_b = {2'b00, den_q};
			end
			fchm_pkg::ST_OUT: m_axis_tvalid = 1'b1;
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fchm_pkg::ST_IDLE;
			min_q <= MOST_POS;
			max_q <= MOST_NEG;
			count_q <= '0;
		end else begin
			state_q <= state_next;
			case (state_q)
				fchm_pkg::ST_IDLE: begin
					if (in_fire && s_axis_tuser[0] == fchm_pkg::REQ_MEASURE
							&& s_axis_tuser[1]) begin
						min_q <= MOST_POS;
						max_q <= MOST_NEG;
					end
					count_q <= '0;
				end
				fchm_pkg::ST_MEAS_MAX: begin
					if (flags.neg) begin
						max_q <= v_q;
					end
				end
				fchm_pkg::ST_MEAS_MIN: begin
					if (flags.neg) begin
						min_q <= v_q;
					end
				end
				fchm_pkg::ST_DIV: count_q <= count_q + 1'b1;
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fchm_pkg::ST_IDLE: begin
				if (in_fire) begin
					v_q <= s_axis_tdata[SAMPLE_BITS-1:0];
				end
				k_q <= '0;
			end
			fchm_pkg::ST_MAP_RANGE: den_q <= diff[SAMPLE_BITS-1:0];
			fchm_pkg::ST_MAP_LOW: rem_q <= diff[SAMPLE_BITS-1:0];
			fchm_pkg::ST_MAP_HIGH: begin
				if (!flags.neg) begin
					k_q <= fchm_pkg::LEVEL_TOP;
				end
			end
			fchm_pkg::ST_DIV: begin
				if (!flags.neg) begin
					rem_q <= diff[SAMPLE_BITS-1:0];
				end else begin
					rem_q <= {rem_q[SAMPLE_BITS-2:0], 1'b0};
				end
				k_q <= {k_q[fchm_pkg::LEVEL_BITS-2:0], ~flags.neg};
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign low = k_q[fchm_pkg::COLOUR_BITS-1:0];

	always_comb begin
		case (k_q[fchm_pkg::LEVEL_BITS-1:fchm_pkg::COLOUR_BITS])
			2'd0: begin
				red = '0;
				green = low;
				blue = '1;
			end
			2'd1: begin
				red = '0;
				green = '1;
				blue = ~low;
			end
			2'd2: begin
				red = low;
				green = '1;
				blue = '0;
			end
			default: begin
				red = '1;
				green = ~low;
				blue = '0;
			end
		endcase
	end

	assign m_axis_tdata = {{(fchm_pkg::OUT_DATA_BITS - fchm_pkg::OUT_FIELD_BITS){1'b0}},
		k_q, blue, green, red};

endmodule

// ----- sim/false_colour_heatmap_mapper_tb.sv -----
module false_colour_heatmap_mapper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BITS = 32;
	localparam int SAMPLE_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct packed {
		logic [fchm_pkg::COLOUR_BITS-1:0] red;
		logic [fchm_pkg::COLOUR_BITS-1:0] green;
		logic [fchm_pkg::COLOUR_BITS-1:0] blue;
		logic [fchm_pkg::LEVEL_BITS-1:0] level;
	} colour_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [SAMPLE_DATA_BITS-1:0] s_axis_tdata;
	logic [fchm_pkg::USER_BITS-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [fchm_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;

	logic signed [SAMPLE_BITS-1:0] frame_lo;
	logic signed [SAMPLE_BITS-1:0] frame_hi;
	colour_t expected_colours[$];
	int items_sent;
	int failures;
	bit idling_on;
	int hold_request;

	false_colour_heatmap_mapper #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [fchm_pkg::LEVEL_BITS-1:0] ramp_index(
			input logic signed [SAMPLE_BITS-1:0] v);
		longint span;
		longint offset;
		if (!(frame_lo < frame_hi))
			return '0;
		if (!(frame_lo < v))
			return '0;
		if (!(v < frame_hi))
			return fchm_pkg::LEVEL_TOP;
		span = longint'(frame_hi) - longint'(frame_lo);
		offset = longint'(v) - longint'(frame_lo);
		return fchm_pkg::LEVEL_BITS'((offset * 1024) / span);
	endfunction

	function automatic colour_t ramp_colour(input logic [fchm_pkg::LEVEL_BITS-1:0] k);
		colour_t c;
		int ki;
		ki = int'(k);
		c.level = k;
		if (ki < 256) begin
			c.red = '0;
			c.green = fchm_pkg::COLOUR_BITS'(ki);
			c.blue = '1;
		end else if (ki < 512) begin
			c.red = '0;
			c.green = '1;
			c.blue = fchm_pkg::COLOUR_BITS'(511 - ki);
		end else if (ki < 768) begin
			c.red = fchm_pkg::COLOUR_BITS'(ki - 512);
			c.green = '1;
			c.blue = '0;
		end else begin
			c.red = '1;
			c.green = fchm_pkg::COLOUR_BITS'(1023 - ki);
			c.blue = '0;
		end
		return c;
	endfunction

	task automatic track_item(input logic req, input logic start,
			input logic signed [SAMPLE_BITS-1:0] v);
		if (req == fchm_pkg::REQ_MEASURE) begin
			if (start) begin
				frame_lo = SAMPLE_TOP;
				frame_hi = SAMPLE_BOTTOM;
			end
			if (frame_hi < v)
				frame_hi = v;
			if (v < frame_lo)
				frame_lo = v;
		end else begin
			expected_colours.push_back(ramp_colour(ramp_index(v)));
		end
	endtask

	task automatic send_item(input logic req, input logic start,
			input logic signed [SAMPLE_BITS-1:0] v);
		int gap;
		@(negedge clk);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= {start, req};
		s_axis_tdata <= SAMPLE_DATA_BITS'(v);
		do @(posedge clk); while (!s_axis_tready);
		track_item(req, start, v);
		items_sent++;
	endtask

	initial begin
		int stall;
		stall = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end else if (stall == 0 && idling_on && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 10);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		colour_t got;
		colour_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = colour_t'({m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
				m_axis_tdata[33:24]});
			if (expected_colours.size() == 0) begin
				$error("unexpected output item: level %0d", got.level);
				failures++;
			end else begin
				want = expected_colours.pop_front();
				if (got.red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, got.red);
					failures++;
				end
				if (got.green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, got.green);
					failures++;
				end
				if (got.blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, got.blue);
					failures++;
				end
				if (got.level !== want.level) begin
					$error("level: expected %0d, got %0d", want.level, got.level);
					failures++;
				end
			end
		end
	end

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
			input logic signed [SAMPLE_BITS-1:0] centre, input int spread_bits);
		logic [SAMPLE_BITS-1:0] offset;
		case ($urandom_range(0, 15))
			0: return SAMPLE_TOP;
			1: return SAMPLE_BOTTOM;
			2: return $urandom;
			default: begin
				offset = SAMPLE_BITS'($urandom & ((64'd1 << spread_bits) - 1));
				return centre + offset - (SAMPLE_BITS'(1) << (spread_bits - 1));
			end
		endcase
	endfunction

	task automatic run_frame();
		logic signed [SAMPLE_BITS-1:0] samples[$];
		logic signed [SAMPLE_BITS-1:0] centre;
		int spread_bits;
		int len;
		bit fresh;
		centre = $urandom;
		spread_bits = $urandom_range(1, 31);
		len = $urandom_range(1, 16);
		fresh = $urandom_range(0, 7) != 0;
		for (int i = 0; i < len; i++)
			samples.push_back(pick_sample(centre, spread_bits));
		foreach (samples[i]) begin
			if ($urandom_range(0, 19) == 0)
				send_item(fchm_pkg::REQ_MAP, 1'($urandom_range(0, 1)), $urandom);
			send_item(fchm_pkg::REQ_MEASURE, fresh && i == 0, samples[i]);
		end
		foreach (samples[i]) begin
			send_item(fchm_pkg::REQ_MAP, $urandom_range(0, 9) == 0, samples[i]);
			if ($urandom_range(0, 7) == 0)
				send_item(fchm_pkg::REQ_MAP, 1'b0, pick_sample(centre, spread_bits));
		end
	endtask

	task automatic test_directed();
		int probes[11] = '{-5, 0, 255, 256, 511, 512, 767, 768, 1023, 1024, 2000};
		send_item(fchm_pkg::REQ_MAP, 1'b1, 0);
		send_item(fchm_pkg::REQ_MEASURE, 1'b1, SAMPLE_BOTTOM);
		send_item(fchm_pkg::REQ_MEASURE, 1'b0, SAMPLE_TOP);
		send_item(fchm_pkg::REQ_MAP, 1'b0, SAMPLE_BOTTOM);
		send_item(fchm_pkg::REQ_MAP, 1'b0, SAMPLE_TOP);
		send_item(fchm_pkg::REQ_MAP, 1'b0, -1);
		send_item(fchm_pkg::REQ_MEASURE, 1'b1, 7);
		send_item(fchm_pkg::REQ_MAP, 1'b0, 7);
		send_item(fchm_pkg::REQ_MEASURE, 1'b1, 1024);
		send_item(fchm_pkg::REQ_MEASURE, 1'b0, 0);
		foreach (probes[i])
			send_item(fchm_pkg::REQ_MAP, 1'b0, probes[i]);
	endtask

	task automatic test_random_frames();
		while (items_sent < 870)
			run_frame();
	endtask

	task automatic test_output_hold();
		hold_request = 300;
		for (int i = 0; i < 40; i++)
			send_item(fchm_pkg::REQ_MAP, 1'b0, $urandom);
	endtask

	task automatic test_steady_stream();
		idling_on = 1'b0;
		repeat (3) run_frame();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = '0;
		s_axis_tdata = '0;
		frame_lo = SAMPLE_TOP;
		frame_hi = SAMPLE_BOTTOM;
		items_sent = 0;
		failures = 0;
		idling_on = 1'b1;
		hold_request = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_frames();
		test_output_hold();
		test_steady_stream();

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (expected_colours.size() == 0);
		repeat (40) @(posedge clk);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/fchm_pkg.sv
rtl/fchm_sub.sv
rtl/false_colour_heatmap_mapper.sv
sim/false_colour_heatmap_mapper_tb.sv
